>>> rtl/core/jlvp_pkg.sv
`timescale 1ns / 1ps

package jlvp_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int ACL_W = 31;
  localparam int JKL_W = 31;
  localparam int SP_W = 17;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 31;

  // dead band round(0.1 * 2^FB)
  localparam logic signed [DW-1:0] BAND = DW'(((64'd1 << FB) + 64'd5) / 64'd10);
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  localparam logic [1:0] KIND_ACTIVE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_ACCEL_LIMIT = 2'd0;
  localparam logic [CFG_AW-1:0] REG_JERK_LIMIT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SAMPLE_PERIOD = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic start;
    alu_op_t op;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic signed [DW-1:0] y;
  } alu_rsp_t;

endpackage

>>> rtl/core/jlvp_alu.sv
`timescale 1ns / 1ps

module jlvp_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  jlvp_pkg::alu_req_t req,
  output jlvp_pkg::alu_rsp_t rsp
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL2,
    A_DIV,
    A_SQRT
  } alu_state_t;

  alu_state_t st_r;
  logic done_r;
  logic signed [31:0] y_r;
  logic [63:0] prod_r;
  logic neg_r;
  logic [47:0] num_r;
  logic [31:0] den_r;
  logic [31:0] rem_r;
  logic [27:0] srem_r;
  logic [23:0] root_r;
  logic [5:0] cnt_r;

  logic [32:0] trial;
  logic qbit;
  logic [27:0] str;
  logic [27:0] sts;
  logic sbit;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    if (s[32] != s[31]) return s[32] ? jlvp_pkg::SMIN : jlvp_pkg::SMAX;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] from_mag(input logic neg, input logic [47:0] m);
    if (neg) begin
      if (m >= 48'h8000_0000) return jlvp_pkg::SMIN;
      return 32'd0 - m[31:0];
    end
    if (m >= 48'h8000_0000) return jlvp_pkg::SMAX;
    return m[31:0];
  endfunction

  always_comb begin
    trial = {rem_r, num_r[47]};
    qbit = (trial >= {1'b0, den_r});
    str = {srem_r[25:0], num_r[47:46]};
    sts = {2'b00, root_r, 2'b01};
    sbit = (str >= sts);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        A_IDLE: begin
          if (req.start) begin
            unique case (req.op)
              jlvp_pkg::OP_ADD: begin
                y_r <= sat33({req.a[31], req.a} + {req.b[31], req.b});
                done_r <= 1'b1;
              end
              jlvp_pkg::OP_SUB: begin
                y_r <= sat33({req.a[31], req.a} - {req.b[31], req.b});
                done_r <= 1'b1;
              end
              jlvp_pkg::OP_MUL: begin
                prod_r <= mag32(req.a) * mag32(req.b);
                neg_r <= req.a[31] ^ req.b[31];
                st_r <= A_MUL2;
              end
              jlvp_pkg::OP_DIV: begin
                if (req.b == '0) begin
                  y_r <= '0;
                  done_r <= 1'b1;
                end else begin
                  num_r <= {mag32(req.a), 16'd0};
                  den_r <= mag32(req.b);
                  rem_r <= '0;
                  neg_r <= req.a[31] ^ req.b[31];
                  cnt_r <= 6'd47;
                  st_r <= A_DIV;
                end
              end
              jlvp_pkg::OP_SQRT: begin
                // negative radicand clamps to zero
                if (req.a[31] || req.a == '0) begin
                  y_r <= '0;
                  done_r <= 1'b1;
                end else begin
                  num_r <= {req.a, 16'd0};
                  srem_r <= '0;
                  root_r <= '0;
                  cnt_r <= 6'd23;
                  st_r <= A_SQRT;
                end
              end
              default: begin
                y_r <= '0;
                done_r <= 1'b1;
              end
            endcase
          end
        end
        A_MUL2: begin
          y_r <= from_mag(neg_r, prod_r[63:16]);
          done_r <= 1'b1;
          st_r <= A_IDLE;
        end
        A_DIV: begin
          // quotient bits shift in behind the dividend
          rem_r <= qbit ? 32'(trial - {1'b0, den_r}) : trial[31:0];
          num_r <= {num_r[46:0], qbit};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            y_r <= from_mag(neg_r, {num_r[46:0], qbit});
            done_r <= 1'b1;
            st_r <= A_IDLE;
          end
        end
        A_SQRT: begin
          srem_r <= sbit ? (str - sts) : str;
          root_r <= {root_r[22:0], sbit};
          num_r <= {num_r[45:0], 2'b00};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            y_r <= {8'd0, root_r[22:0], sbit};
            done_r <= 1'b1;
            st_r <= A_IDLE;
          end
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.y = y_r;

endmodule

>>> rtl/core/jerk_limited_velocity_profile_top.sv
`timescale 1ns / 1ps
// jerk-limited velocity reference generator, Q16.16
// input channel in_valid/in_ready carries one tick: kind, target, start
// velocity and start acceleration. result channel out_valid/out_ready gives
// velocity, acceleration and jerk references, one item per input item.
// cfg_we/cfg_addr/cfg_wdata write accel limit (0), jerk limit (1) and
// sample period (2); write only while idle, other indexes are ignored.
// the main arithmetic runs through one shared unit (halving and some
// negations are done beside it): saturating add/sub, a 32x32 multiply,
// a 48-step restoring divider and a 24-step square root, sequenced by the
// state machine below. a passthrough item skips the arithmetic; an active
// item without replanning advances its elapsed time by the sample period
// and runs the steps of its profile phase; a replanning item runs the
// planning steps before its phase steps, and the short profile branch of the plan also runs the square root.
// in_ready is high only while the sequencer is idle; one item is worked at
// a time. a finished result sits in the output register until taken, and
// the next item is accepted meanwhile; its result waits if the register is
// still full. reset clears state, held plan and the output valid.

module jerk_limited_velocity_profile_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_target_velocity,
  input  logic signed [31:0] in_start_velocity,
  input  logic signed [31:0] in_start_accel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_velocity_ref,
  output logic signed [31:0] out_accel_ref,
  output logic signed [31:0] out_jerk_ref,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [30:0]        cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE, S_ADV,
    S_P_VD, S_P_AD, S_P_T1, S_P_M1, S_P_M2, S_P_M3, S_P_V1, S_P_T3, S_P_M4, S_P_M5,
    S_P_CHK, S_P_S1, S_P_S2, S_P_T23, S_P_SEL, S_P_E1, S_P_E2,
    S_Q_JJ, S_Q_JJ2, S_Q_AA, S_Q_D1, S_Q_D2, S_Q_R, S_Q_SQ, S_Q_NA, S_Q_D3,
    S_Q_T1, S_Q_PE2, S_Q_M, S_Q_PL,
    S_E_SEL, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7,
    S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10, S_C11,
    S_DONE
  } state_t;

  state_t state_r;
  logic wait_r;
  logic ph_c_r;

  logic [30:0] acl_r, jkl_r;
  logic [16:0] sp_r;

  logic signed [31:0] et_r, ht_r, hsv_r, hsa_r, pl_r, rdj_r, ruj_r;
  logic signed [31:0] pe0_r, pe1_r, pe2_r;
  logic [1:0] pk_r;

  logic signed [31:0] x_r, y_r, z_r, s_r, vd_r, ad_r, t1_r, v1_r, t3d_r, v3_r, t23_r;
  logic signed [31:0] vel_r, acc_r, jrk_r;

  logic out_valid_r;
  logic signed [31:0] out_vel_r, out_acc_r, out_jrk_r;

  jlvp_pkg::alu_req_t req;
  jlvp_pkg::alu_rsp_t rsp;
  logic signed [31:0] res;
  logic signed [31:0] res_h;
  logic signed [31:0] lim_a, lim_j, sp_ext;
  logic use_alu;

  function automatic logic signed [31:0] half32(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v + {31'd0, v[31]};
    return t >>> 1;
  endfunction

  assign lim_a = {1'b0, acl_r};
  assign lim_j = {1'b0, jkl_r};
  assign sp_ext = {15'd0, sp_r};
  assign res = rsp.y;
  assign res_h = half32(rsp.y);

  jlvp_alu u_alu (
    .clk(clk),
    .rst_n(rst_n),
    .req(req),
    .rsp(rsp)
  );

  always_comb begin
    use_alu = 1'b1;
    req.op = jlvp_pkg::OP_ADD;
    req.a = '0;
    req.b = '0;
    unique case (state_r)
      S_ADV:   begin req.a = et_r; req.b = sp_ext; end
      S_P_VD:  begin req.op = jlvp_pkg::OP_SUB; req.a = hsv_r; req.b = hsv_r; end
      S_P_AD:  begin req.op = jlvp_pkg::OP_SUB; req.a = pl_r; req.b = hsa_r; end
      S_P_T1:  begin req.op = jlvp_pkg::OP_DIV; req.a = ad_r; req.b = lim_j; end
      S_P_M1:  begin req.op = jlvp_pkg::OP_MUL; req.a = ruj_r; req.b = t1_r; end
      S_P_M2:  begin req.op = jlvp_pkg::OP_MUL; req.a = x_r; req.b = t1_r; end
      S_P_M3:  begin req.op = jlvp_pkg::OP_MUL; req.a = hsa_r; req.b = t1_r; end
      S_P_V1:  begin req.a = x_r; req.b = y_r; end
      S_P_T3:  begin req.op = jlvp_pkg::OP_DIV; req.a = lim_a; req.b = lim_j; end
      S_P_M4:  begin req.op = jlvp_pkg::OP_MUL; req.a = rdj_r; req.b = t3d_r; end
      S_P_M5:  begin req.op = jlvp_pkg::OP_MUL; req.a = x_r; req.b = t3d_r; end
      S_P_S1:  begin req.op = jlvp_pkg::OP_SUB; req.a = vd_r; req.b = v1_r; end
      S_P_S2:  begin req.op = jlvp_pkg::OP_SUB; req.a = x_r; req.b = v3_r; end
      S_P_T23: begin req.op = jlvp_pkg::OP_DIV; req.a = x_r; req.b = pl_r; end
      S_P_E1:  begin req.a = t1_r; req.b = t23_r; end
      S_P_E2:  begin req.a = pe1_r; req.b = t3d_r; end
      S_Q_JJ:  begin req.op = jlvp_pkg::OP_MUL; req.a = ruj_r; req.b = ruj_r; end
      S_Q_JJ2: begin req.a = x_r; req.b = x_r; end
      S_Q_AA:  begin req.op = jlvp_pkg::OP_MUL; req.a = hsa_r; req.b = hsa_r; end
      S_Q_D1:  begin req.op = jlvp_pkg::OP_DIV; req.a = y_r; req.b = x_r; end
      S_Q_D2:  begin req.op = jlvp_pkg::OP_DIV; req.a = vd_r; req.b = ruj_r; end
      S_Q_R:   begin req.a = y_r; req.b = z_r; end
      S_Q_SQ:  begin req.op = jlvp_pkg::OP_SQRT; req.a = x_r; end
      S_Q_NA:  begin req.op = jlvp_pkg::OP_SUB; req.a = '0; req.b = hsa_r; end
      S_Q_D3:  begin req.op = jlvp_pkg::OP_DIV; req.a = z_r; req.b = ruj_r; end
      S_Q_T1:  begin req.a = y_r; req.b = s_r; end
      S_Q_PE2: begin req.a = t1_r; req.b = s_r; end
      S_Q_M:   begin req.op = jlvp_pkg::OP_MUL; req.a = ruj_r; req.b = t1_r; end
      S_Q_PL:  begin req.a = x_r; req.b = hsa_r; end
      S_A1:    begin req.op = jlvp_pkg::OP_MUL; req.a = ruj_r; req.b = et_r; end
      S_A2:    begin req.a = x_r; req.b = hsa_r; end
      S_A3:    begin req.op = jlvp_pkg::OP_MUL; req.a = x_r; req.b = et_r; end
      S_A4:    begin req.op = jlvp_pkg::OP_MUL; req.a = hsa_r; req.b = et_r; end
      S_A5:    begin req.a = x_r; req.b = y_r; end
      S_A6:    begin req.a = x_r; req.b = hsv_r; end
      S_B0:    begin req.op = jlvp_pkg::OP_MUL; req.a = ruj_r; req.b = pe0_r; end
      S_B1:    begin req.op = jlvp_pkg::OP_MUL; req.a = x_r; req.b = pe0_r; end
      S_B2:    begin req.a = hsv_r; req.b = x_r; end
      S_B3:    begin req.op = jlvp_pkg::OP_MUL; req.a = hsa_r; req.b = pe0_r; end
      S_B4:    begin req.a = x_r; req.b = y_r; end
      S_B5:    begin req.op = jlvp_pkg::OP_SUB; req.a = et_r; req.b = pe0_r; end
      S_B6:    begin req.op = jlvp_pkg::OP_MUL; req.a = pl_r; req.b = y_r; end
      S_B7:    begin req.a = x_r; req.b = y_r; end
      S_C1:    begin req.op = jlvp_pkg::OP_SUB; req.a = et_r; req.b = pe1_r; end
      S_C2:    begin req.op = jlvp_pkg::OP_MUL; req.a = rdj_r; req.b = y_r; end
      S_C3:    begin req.op = jlvp_pkg::OP_SUB; req.a = pl_r; req.b = z_r; end
      S_C4:    begin req.op = jlvp_pkg::OP_SUB; req.a = pe1_r; req.b = pe0_r; end
      S_C5:    begin req.op = jlvp_pkg::OP_MUL; req.a = pl_r; req.b = z_r; end
      S_C6:    begin req.a = x_r; req.b = z_r; end
      S_C7:    begin req.op = jlvp_pkg::OP_MUL; req.a = pl_r; req.b = y_r; end
      S_C8:    begin req.a = x_r; req.b = z_r; end
      S_C9:    begin req.op = jlvp_pkg::OP_MUL; req.a = rdj_r; req.b = y_r; end
      S_C10:   begin req.op = jlvp_pkg::OP_MUL; req.a = z_r; req.b = y_r; end
      S_C11:   begin req.op = jlvp_pkg::OP_SUB; req.a = x_r; req.b = z_r; end
      default: use_alu = 1'b0;
    endcase
    // velocity difference uses the new target against the start velocity
    if (state_r == S_P_VD) begin
      req.a = ht_r;
    end
    req.start = use_alu && !wait_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wait_r <= 1'b0;
      ph_c_r <= 1'b0;
      acl_r <= 31'd131072;
      jkl_r <= 31'd131072;
      sp_r <= 17'd655;
      et_r <= '0;
      ht_r <= '0;
      hsv_r <= '0;
      hsa_r <= '0;
      pl_r <= '0;
      rdj_r <= '0;
      ruj_r <= '0;
      pe0_r <= '0;
      pe1_r <= '0;
      pe2_r <= '0;
      pk_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          jlvp_pkg::REG_ACCEL_LIMIT:   acl_r <= cfg_wdata;
          jlvp_pkg::REG_JERK_LIMIT:    jkl_r <= cfg_wdata;
          jlvp_pkg::REG_SAMPLE_PERIOD: sp_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      if (use_alu && !wait_r) wait_r <= 1'b1;

      if (state_r == S_IDLE) begin
        if (in_valid) begin
          pk_r <= in_kind;
          if (in_kind != jlvp_pkg::KIND_ACTIVE) begin
            vel_r <= in_start_velocity;
            acc_r <= in_start_accel;
            jrk_r <= '0;
            state_r <= S_DONE;
          end else if (in_target_velocity != ht_r || in_kind > pk_r) begin
            ht_r <= in_target_velocity;
            hsv_r <= in_start_velocity;
            hsa_r <= in_start_accel;
            et_r <= '0;
            state_r <= S_P_VD;
          end else begin
            state_r <= S_ADV;
          end
        end
      end else if (state_r == S_DONE) begin
        if (!out_valid_r || out_ready) begin
          out_vel_r <= vel_r;
          out_acc_r <= acc_r;
          out_jrk_r <= jrk_r;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
      end else if (state_r == S_P_CHK) begin
        if (pl_r == '0) begin
          t23_r <= '0;
          state_r <= S_P_SEL;
        end else begin
          state_r <= S_P_S1;
        end
      end else if (state_r == S_P_SEL) begin
        if (t23_r[31]) begin
          state_r <= S_Q_JJ;
        end else begin
          pe0_r <= t1_r;
          state_r <= S_P_E1;
        end
      end else if (state_r == S_E_SEL) begin
        priority if (et_r < pe0_r) begin
          jrk_r <= ruj_r;
          state_r <= S_A1;
        end else if (et_r < pe1_r) begin
          jrk_r <= '0;
          acc_r <= pl_r;
          ph_c_r <= 1'b0;
          state_r <= S_B0;
        end else if (et_r < pe2_r) begin
          // ramp-down jerk is a limit or zero, so the negation cannot overflow
          jrk_r <= 32'sd0 - rdj_r;
          ph_c_r <= 1'b1;
          state_r <= S_B0;
        end else begin
          jrk_r <= '0;
          acc_r <= '0;
          vel_r <= ht_r;
          state_r <= S_DONE;
        end
      end else if (wait_r && rsp.done) begin
        wait_r <= 1'b0;
        unique case (state_r)
          S_ADV: begin et_r <= res; state_r <= S_E_SEL; end
          S_P_VD: begin
            vd_r <= res;
            if (res >= -jlvp_pkg::BAND && res <= jlvp_pkg::BAND) begin
              pl_r <= '0;
              rdj_r <= '0;
            end else begin
              pl_r <= res[31] ? -lim_a : lim_a;
              rdj_r <= res[31] ? -lim_j : lim_j;
            end
            state_r <= S_P_AD;
          end
          S_P_AD: begin
            ad_r <= res;
            ruj_r <= res[31] ? -lim_j : ((res == '0) ? '0 : lim_j);
            state_r <= S_P_T1;
          end
          S_P_T1: begin
            t1_r <= res[31] ? ((res == jlvp_pkg::SMIN) ? jlvp_pkg::SMAX : -res) : res;
            state_r <= S_P_M1;
          end
          S_P_M1: begin x_r <= res; state_r <= S_P_M2; end
          S_P_M2: begin x_r <= res_h; state_r <= S_P_M3; end
          S_P_M3: begin y_r <= res; state_r <= S_P_V1; end
          S_P_V1: begin v1_r <= res; state_r <= S_P_T3; end
          S_P_T3: begin t3d_r <= res; state_r <= S_P_M4; end
          S_P_M4: begin x_r <= res; state_r <= S_P_M5; end
          S_P_M5: begin v3_r <= res_h; state_r <= S_P_CHK; end
          S_P_S1: begin x_r <= res; state_r <= S_P_S2; end
          S_P_S2: begin x_r <= res; state_r <= S_P_T23; end
          S_P_T23: begin t23_r <= res; state_r <= S_P_SEL; end
          S_P_E1: begin pe1_r <= res; state_r <= S_P_E2; end
          S_P_E2: begin pe2_r <= res; state_r <= S_E_SEL; end
          S_Q_JJ: begin x_r <= res; state_r <= S_Q_JJ2; end
          S_Q_JJ2: begin x_r <= res; state_r <= S_Q_AA; end
          S_Q_AA: begin y_r <= res; state_r <= S_Q_D1; end
          S_Q_D1: begin y_r <= res; state_r <= S_Q_D2; end
          S_Q_D2: begin z_r <= res; state_r <= S_Q_R; end
          S_Q_R: begin x_r <= res; state_r <= S_Q_SQ; end
          S_Q_SQ: begin s_r <= res; state_r <= S_Q_NA; end
          S_Q_NA: begin z_r <= res; state_r <= S_Q_D3; end
          S_Q_D3: begin y_r <= res; state_r <= S_Q_T1; end
          S_Q_T1: begin
            t1_r <= res;
            pe0_r <= res;
            pe1_r <= res;
            state_r <= S_Q_PE2;
          end
          S_Q_PE2: begin pe2_r <= res; state_r <= S_Q_M; end
          S_Q_M: begin x_r <= res; state_r <= S_Q_PL; end
          S_Q_PL: begin pl_r <= res; state_r <= S_E_SEL; end
          S_A1: begin x_r <= res; state_r <= S_A2; end
          S_A2: begin acc_r <= res; state_r <= S_A3; end
          S_A3: begin x_r <= res_h; state_r <= S_A4; end
          S_A4: begin y_r <= res; state_r <= S_A5; end
          S_A5: begin x_r <= res; state_r <= S_A6; end
          S_A6: begin vel_r <= res; state_r <= S_DONE; end
          S_B0: begin x_r <= res; state_r <= S_B1; end
          S_B1: begin x_r <= res_h; state_r <= S_B2; end
          S_B2: begin x_r <= res; state_r <= S_B3; end
          S_B3: begin y_r <= res; state_r <= S_B4; end
          S_B4: begin x_r <= res; state_r <= ph_c_r ? S_C1 : S_B5; end
          S_B5: begin y_r <= res; state_r <= S_B6; end
          S_B6: begin y_r <= res; state_r <= S_B7; end
          S_B7: begin vel_r <= res; state_r <= S_DONE; end
          S_C1: begin y_r <= res; state_r <= S_C2; end
          S_C2: begin z_r <= res; state_r <= S_C3; end
          S_C3: begin acc_r <= res; state_r <= S_C4; end
          S_C4: begin z_r <= res; state_r <= S_C5; end
          S_C5: begin z_r <= res; state_r <= S_C6; end
          S_C6: begin x_r <= res; state_r <= S_C7; end
          S_C7: begin z_r <= res; state_r <= S_C8; end
          S_C8: begin x_r <= res; state_r <= S_C9; end
          S_C9: begin z_r <= res; state_r <= S_C10; end
          S_C10: begin z_r <= res_h; state_r <= S_C11; end
          S_C11: begin vel_r <= res; state_r <= S_DONE; end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_velocity_ref = out_vel_r;
  assign out_accel_ref = out_acc_r;
  assign out_jerk_ref = out_jrk_r;

endmodule

>>> rtl/core/jlvp_checker.sv
`timescale 1ns / 1ps

module jlvp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_velocity_ref,
  input logic signed [31:0] out_accel_ref,
  input logic signed [31:0] out_jerk_ref
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_velocity_ref) && $stable(out_accel_ref)
      && $stable(out_jerk_ref))
    else $error("stalled result item changed");

  // one item at a time: ready drops after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind jerk_limited_velocity_profile_top jlvp_checker u_jlvp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_velocity_ref(out_velocity_ref),
  .out_accel_ref(out_accel_ref),
  .out_jerk_ref(out_jerk_ref)
);
